/* rtl/i2cmra_pkg.sv */
// shared types and constants for the i2c register access master
`default_nettype none
package i2cmra_pkg;

    localparam int MAX_BYTES = 16;
    localparam int IDX_W     = $clog2(MAX_BYTES);
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    localparam logic [6:0] DEV_ADDR_RESET = 7'd104;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PUSH  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BUS_BUSY  = 2'd1,
        ST_ADDR_NACK = 2'd2,
        ST_DATA_NACK = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START1    = 4'd1,
        PH_ADDRW     = 4'd2,
        PH_ADDRW_ACK = 4'd3,
        PH_REG       = 4'd4,
        PH_REG_ACK   = 4'd5,
        PH_DATA      = 4'd6,
        PH_DATA_ACK  = 4'd7,
        PH_START2    = 4'd8,
        PH_ADDRR     = 4'd9,
        PH_ADDRR_ACK = 4'd10,
        PH_RECV      = 4'd11,
        PH_MACK      = 4'd12,
        PH_STOP      = 4'd13
    } t_phase;

    typedef struct packed {
        logic [1:0] op;
        logic       sda_in;
        logic [7:0] reg_addr;
        logic [4:0] length;
        logic [7:0] data_byte;
    } t_request;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_data;
        logic       read_last;
        logic       done_res;
        logic [1:0] status;
        logic       push_dropped;
    } t_result;

endpackage
`default_nettype wire

/* rtl/i2c_master_register_access.sv */
// i2c master for register-addressed devices, at most one bus tick per request
//
// Input channel: i_in_valid / o_in_stall carry one request (op, sampled sda,
// register address, length, data byte). A request is taken at a clock edge
// with i_in_valid high and o_in_stall low. Op tick advances the bus by one
// delay tick, op push queues a write byte, ops write and read start a
// transaction when idle.
// Output channel: o_out_valid / i_out_stall carry one result per request
// (scl/sda drives, busy, received byte, done, status, push dropped).
// The result of a request sits in the output register the cycle after it is
// taken. One request is taken per clock while the receiver does not stall;
// the whole tick update is a single pass through the phase state machine.
// When the receiver stalls, the output register holds and o_in_stall rises
// only while a result waits, so a new request is taken in the same cycle
// its predecessor's result leaves.
// Reset (i_rst_n low, synchronous) empties the output register, sets the
// phase to idle, releases both lines and loads device address 0x68. The
// write buffer is not cleared. i_cfg_wr_en loads the device address; the
// user must use it only while idle, the block itself does not enforce this.
`default_nettype none
module i2c_master_register_access (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_wr_en,
    input  wire  [6:0]             i_cfg_wr_data,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire i2cmra_pkg::t_request i_in_data,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output i2cmra_pkg::t_result    o_out_data
);
    import i2cmra_pkg::*;

    logic [6:0]       r_dev_addr;
    t_phase           r_phase, n_phase;
    logic [2:0]       r_tick, n_tick;
    logic [3:0]       r_bit, n_bit;
    logic [7:0]       r_shift, n_shift;
    logic [CNT_W-1:0] r_left, n_left;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_send, n_send;
    logic             r_is_read, n_is_read;
    logic [7:0]       r_held, n_held;
    logic             r_scl, n_scl;
    logic             r_sda, n_sda;
    logic [1:0]       r_abort, n_abort;
    logic [7:0]       r_buf [MAX_BYTES];
    logic [7:0]       r_rd_byte;
    logic             r_out_valid;
    t_result          r_res, n_res;

    logic             accept;
    logic             buf_we;
    logic [IDX_W-1:0] rd_idx;
    logic [CNT_W-1:0] send_inc;
    logic [CNT_W-1:0] left_dec;
    logic [3:0]       bit_inc;
    logic [7:0]       rx_byte;
    logic             sdi;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_res;

    assign sdi      = i_in_data.sda_in;
    assign send_inc = r_send + CNT_W'(1);
    assign left_dec = r_left - CNT_W'(1);
    assign bit_inc  = r_bit + 4'd1;
    assign rx_byte  = {r_shift[6:0], sdi};
    // data ack moves on to the next entry, all other phases use the current one
    assign rd_idx   = (r_phase == PH_DATA_ACK) ? send_inc[IDX_W-1:0] : r_send[IDX_W-1:0];

    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_left    = r_left;
        n_fill    = r_fill;
        n_send    = r_send;
        n_is_read = r_is_read;
        n_held    = r_held;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_abort   = r_abort;
        buf_we    = 1'b0;
        n_res     = '0;

        unique case (t_op'(i_in_data.op))
            OP_PUSH: begin
                if (r_phase != PH_IDLE || r_fill >= CNT_W'(MAX_BYTES)) begin
                    n_res.push_dropped = 1'b1;
                end else begin
                    buf_we = 1'b1;
                    n_fill = r_fill + CNT_W'(1);
                end
            end
            OP_WRITE, OP_READ: begin
                if (r_phase == PH_IDLE) begin
                    n_is_read = (t_op'(i_in_data.op) == OP_READ);
                    n_held    = i_in_data.reg_addr;
                    if (int'(i_in_data.length) > MAX_BYTES) begin
                        n_left = CNT_W'(MAX_BYTES);
                    end else begin
                        n_left = CNT_W'(i_in_data.length);
                    end
                    n_send  = '0;
                    n_abort = ST_OK;
                    if (t_op'(i_in_data.op) == OP_WRITE) begin
                        n_fill = '0;
                    end
                    n_phase = PH_START1;
                    n_tick  = '0;
                    n_bit   = '0;
                    n_shift = '0;
                end
            end
            OP_TICK: begin
                unique case (r_phase)
                    PH_IDLE: begin
                        // lines hold and sda is ignored
                    end
                    PH_START1, PH_START2: begin
                        if (r_tick < 3'd2) begin
                            n_scl = 1'b1;
                            n_sda = 1'b1;
                        end else begin
                            n_sda = 1'b0;
                        end
                        if ((r_tick == 3'd1 && !sdi) || (r_tick == 3'd2 && sdi)) begin
                            // bus not free: give up at once without stop
                            n_phase        = PH_IDLE;
                            n_tick         = '0;
                            n_bit          = '0;
                            n_shift        = '0;
                            n_res.done_res = 1'b1;
                            n_res.status   = ST_BUS_BUSY;
                        end else if (r_tick == 3'd4) begin
                            n_tick = '0;
                            n_bit  = '0;
                            if (r_phase == PH_START1) begin
                                n_phase = PH_ADDRW;
                                n_shift = {r_dev_addr, 1'b0};
                            end else begin
                                n_phase = PH_ADDRR;
                                n_shift = {r_dev_addr, 1'b1};
                            end
                        end else begin
                            n_tick = r_tick + 3'd1;
                        end
                    end
                    PH_ADDRW, PH_REG, PH_DATA, PH_ADDRR: begin
                        if (r_tick == 3'd0) begin
                            n_scl = 1'b0;
                        end else if (r_tick == 3'd1) begin
                            n_sda = r_shift[7];
                        end else begin
                            n_scl = 1'b1;
                        end
                        if (r_tick < 3'd2) begin
                            n_tick = r_tick + 3'd1;
                        end else begin
                            n_tick  = '0;
                            n_shift = {r_shift[6:0], 1'b0};
                            n_bit   = bit_inc;
                            if (bit_inc == 4'd8) begin
                                n_bit   = '0;
                                n_shift = '0;
                                priority case (r_phase)
                                    PH_ADDRW: n_phase = PH_ADDRW_ACK;
                                    PH_REG:   n_phase = PH_REG_ACK;
                                    PH_DATA:  n_phase = PH_DATA_ACK;
                                    default:  n_phase = PH_ADDRR_ACK;
                                endcase
                            end
                        end
                    end
                    PH_ADDRW_ACK, PH_REG_ACK, PH_DATA_ACK, PH_ADDRR_ACK: begin
                        if (r_tick == 3'd0) begin
                            n_scl = 1'b0;
                        end else if (r_tick == 3'd1) begin
                            n_sda = 1'b1;
                        end else if (r_tick <= 3'd5) begin
                            n_scl = 1'b1;
                        end
                        if (r_tick == 3'd5) begin
                            n_shift = {7'd0, sdi};
                        end
                        if (r_tick < 3'd6) begin
                            n_tick = r_tick + 3'd1;
                        end else begin
                            n_scl   = 1'b0;
                            n_tick  = '0;
                            n_bit   = '0;
                            n_shift = '0;
                            priority case (r_phase)
                                PH_ADDRW_ACK: begin
                                    if (r_shift[0]) begin
                                        n_abort = ST_ADDR_NACK;
                                        n_phase = PH_STOP;
                                    end else begin
                                        n_phase = PH_REG;
                                        n_shift = r_held;
                                    end
                                end
                                PH_REG_ACK: begin
                                    if (r_is_read) begin
                                        n_phase = PH_START2;
                                    end else if (r_left == '0) begin
                                        n_phase = PH_STOP;
                                    end else begin
                                        n_phase = PH_DATA;
                                        n_shift = r_rd_byte;
                                    end
                                end
                                PH_DATA_ACK: begin
                                    if (r_shift[0]) begin
                                        n_abort = ST_DATA_NACK;
                                        n_phase = PH_STOP;
                                    end else begin
                                        n_send = send_inc;
                                        n_left = left_dec;
                                        if (left_dec == '0) begin
                                            n_phase = PH_STOP;
                                        end else begin
                                            n_phase = PH_DATA;
                                            n_shift = r_rd_byte;
                                        end
                                    end
                                end
                                default: begin
                                    if (r_left == '0) begin
                                        n_phase = PH_STOP;
                                    end else begin
                                        n_phase = PH_RECV;
                                    end
                                end
                            endcase
                        end
                    end
                    PH_RECV: begin
                        if (r_tick == 3'd0) begin
                            n_scl  = 1'b0;
                            n_sda  = 1'b1;
                            n_tick = 3'd1;
                        end else begin
                            n_scl   = 1'b1;
                            n_shift = rx_byte;
                            n_bit   = bit_inc;
                            n_tick  = '0;
                            if (bit_inc == 4'd8) begin
                                n_res.read_valid = 1'b1;
                                n_res.read_data  = rx_byte;
                                n_res.read_last  = (r_left == CNT_W'(1));
                                n_phase          = PH_MACK;
                                n_bit            = '0;
                                n_shift          = '0;
                            end
                        end
                    end
                    PH_MACK: begin
                        if (r_tick == 3'd0) begin
                            n_scl = 1'b0;
                        end else if (r_tick == 3'd1) begin
                            // nack after the last byte
                            n_sda = (r_left <= CNT_W'(1));
                        end else if (r_tick == 3'd2) begin
                            n_scl = 1'b1;
                        end else begin
                            n_scl = 1'b0;
                        end
                        if (r_tick < 3'd3) begin
                            n_tick = r_tick + 3'd1;
                        end else begin
                            n_left  = left_dec;
                            n_tick  = '0;
                            n_bit   = '0;
                            n_shift = '0;
                            n_phase = (left_dec == '0) ? PH_STOP : PH_RECV;
                        end
                    end
                    PH_STOP: begin
                        if (r_tick == 3'd0) begin
                            n_scl = 1'b0;
                        end else if (r_tick == 3'd1) begin
                            n_sda = 1'b0;
                        end else if (r_tick == 3'd2) begin
                            n_scl = 1'b1;
                        end else begin
                            n_sda = 1'b1;
                        end
                        if (r_tick < 3'd3) begin
                            n_tick = r_tick + 3'd1;
                        end else begin
                            n_phase        = PH_IDLE;
                            n_tick         = '0;
                            n_bit          = '0;
                            n_shift        = '0;
                            n_res.done_res = 1'b1;
                            n_res.status   = r_abort;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_tick  = '0;
                        n_bit   = '0;
                        n_shift = '0;
                    end
                endcase
            end
            default: begin
            end
        endcase

        n_res.scl_out  = n_scl;
        n_res.sda_out  = n_sda;
        n_res.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr  <= DEV_ADDR_RESET;
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_left      <= '0;
            r_fill      <= '0;
            r_send      <= '0;
            r_is_read   <= 1'b0;
            r_held      <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_abort     <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_dev_addr <= i_cfg_wr_data;
            end
            if (accept) begin
                r_phase   <= n_phase;
                r_tick    <= n_tick;
                r_bit     <= n_bit;
                r_shift   <= n_shift;
                r_left    <= n_left;
                r_fill    <= n_fill;
                r_send    <= n_send;
                r_is_read <= n_is_read;
                r_held    <= n_held;
                r_scl     <= n_scl;
                r_sda     <= n_sda;
                r_abort   <= n_abort;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && buf_we) begin
            r_buf[r_fill[IDX_W-1:0]] <= i_in_data.data_byte;
        end
        // next byte to send, settled long before the seven acknowledge ticks end
        r_rd_byte <= r_buf[rd_idx];
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(MAX_BYTES))
        else $error("write queue count beyond capacity");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> !o_out_data.busy_res)
        else $error("done reported while still busy");

    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.done_res)
        else $error("error status without done");

    a_rx_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.read_valid |-> o_out_data.busy_res && r_is_read)
        else $error("received byte outside a read");

    a_write_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && t_op'(i_in_data.op) == OP_WRITE && r_phase == PH_IDLE |=> r_fill == '0)
        else $error("write start left bytes queued");

endmodule
`default_nettype wire

/* tb/sv/tb_i2c_master_register_access.sv */
// self-checking testbench for the i2c register access master: bus model scoreboard
module tb_i2c_master_register_access;
    timeunit 1ns;
    timeprecision 1ps;
    import i2cmra_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_SHOWN   = 10;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 10;

    typedef enum int {
        FLT_NONE,
        FLT_START1,
        FLT_START2,
        FLT_ADDR_NACK,
        FLT_DATA_NACK
    } t_fault;

    typedef enum int {
        PACE_FULL,
        PACE_SOME,
        PACE_HEAVY
    } t_pace;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [6:0] cfg_wr_data = '0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    t_request   in_req      = '0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    t_result    out_res;

    i2c_master_register_access u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_data     (in_req),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_data    (out_res)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // bus model state
    logic [6:0] bus_dev;
    t_phase     bus_phase;
    logic [2:0] bus_tick_n;
    logic [3:0] bus_bits;
    logic [7:0] bus_shift;
    logic [4:0] bus_left;
    logic [7:0] bus_fifo [MAX_BYTES];
    logic [4:0] bus_fill;
    logic [4:0] bus_idx;
    logic       bus_rd;
    logic [7:0] bus_reg;
    logic       bus_scl;
    logic       bus_sda;
    t_status    bus_abort;

    t_request request_q [$];
    t_result  bus_drive_q [$];

    int    item_count;
    int    noise_pct;
    t_pace src_mode;
    t_pace sink_mode;
    int    src_gap;
    int    sink_wait;
    int    hold_left;
    bit    hold_done;
    int    accepted_n;
    int    result_n;
    int    mismatch_n;
    int    bytes_read;
    int    done_by_status [4];
    int    cycle_n;

    task automatic bus_enter(t_phase p, logic [7:0] b);
        bus_phase  = p;
        bus_tick_n = '0;
        bus_bits   = '0;
        bus_shift  = b;
    endtask

    task automatic bus_reset();
        bus_dev = DEV_ADDR_RESET;
        bus_enter(PH_IDLE, 8'h00);
        bus_left  = '0;
        bus_fill  = '0;
        bus_idx   = '0;
        bus_rd    = 1'b0;
        bus_reg   = '0;
        bus_scl   = 1'b1;
        bus_sda   = 1'b1;
        bus_abort = ST_OK;
        foreach (bus_fifo[i]) bus_fifo[i] = '0;
    endtask

    task automatic bus_after_ack(logic nack);
        case (bus_phase)
            PH_ADDRW_ACK: begin
                if (nack) begin
                    bus_abort = ST_ADDR_NACK;
                    bus_enter(PH_STOP, 8'h00);
                end else begin
                    bus_enter(PH_REG, bus_reg);
                end
            end
            PH_REG_ACK: begin
                if (bus_rd) bus_enter(PH_START2, 8'h00);
                else if (bus_left == 0) bus_enter(PH_STOP, 8'h00);
                else bus_enter(PH_DATA, bus_fifo[bus_idx[3:0]]);
            end
            PH_DATA_ACK: begin
                if (nack) begin
                    bus_abort = ST_DATA_NACK;
                    bus_enter(PH_STOP, 8'h00);
                end else begin
                    bus_idx  = bus_idx + 5'd1;
                    bus_left = bus_left - 5'd1;
                    if (bus_left == 0) bus_enter(PH_STOP, 8'h00);
                    else bus_enter(PH_DATA, bus_fifo[bus_idx[3:0]]);
                end
            end
            default: begin
                // read address acknowledge, its value is ignored
                if (bus_left == 0) bus_enter(PH_STOP, 8'h00);
                else bus_enter(PH_RECV, 8'h00);
            end
        endcase
    endtask

    task automatic bus_tick(logic sdi, inout t_result res);
        logic [2:0] t;
        t = bus_tick_n;
        case (bus_phase)
            PH_START1, PH_START2: begin
                if (t < 2) begin
                    bus_scl = 1'b1;
                    bus_sda = 1'b1;
                end else begin
                    bus_sda = 1'b0;
                end
                if ((t == 1 && !sdi) || (t == 2 && sdi)) begin
                    // bus not free: end at once, lines keep their levels
                    bus_enter(PH_IDLE, 8'h00);
                    res.done_res = 1'b1;
                    res.status   = ST_BUS_BUSY;
                end else if (t == 4) begin
                    if (bus_phase == PH_START1) bus_enter(PH_ADDRW, {bus_dev, 1'b0});
                    else bus_enter(PH_ADDRR, {bus_dev, 1'b1});
                end else begin
                    bus_tick_n = t + 3'd1;
                end
            end
            PH_ADDRW, PH_REG, PH_DATA, PH_ADDRR: begin
                if (t == 0) bus_scl = 1'b0;
                else if (t == 1) bus_sda = bus_shift[7];
                else bus_scl = 1'b1;
                if (t < 2) begin
                    bus_tick_n = t + 3'd1;
                end else begin
                    bus_tick_n = '0;
                    bus_shift  = {bus_shift[6:0], 1'b0};
                    bus_bits   = bus_bits + 4'd1;
                    if (bus_bits == 8) bus_enter(t_phase'(bus_phase + 4'd1), 8'h00);
                end
            end
            PH_ADDRW_ACK, PH_REG_ACK, PH_DATA_ACK, PH_ADDRR_ACK: begin
                if (t == 0) bus_scl = 1'b0;
                else if (t == 1) bus_sda = 1'b1;
                else if (t <= 5) bus_scl = 1'b1;
                if (t == 5) bus_shift = {7'd0, sdi};
                if (t < 6) begin
                    bus_tick_n = t + 3'd1;
                end else begin
                    bus_scl = 1'b0;
                    bus_after_ack(bus_shift[0]);
                end
            end
            PH_RECV: begin
                if (t == 0) begin
                    bus_scl    = 1'b0;
                    bus_sda    = 1'b1;
                    bus_tick_n = 3'd1;
                end else begin
                    bus_scl    = 1'b1;
                    bus_shift  = {bus_shift[6:0], sdi};
                    bus_bits   = bus_bits + 4'd1;
                    bus_tick_n = '0;
                    if (bus_bits == 8) begin
                        res.read_valid = 1'b1;
                        res.read_data  = bus_shift;
                        res.read_last  = (bus_left == 1);
                        bus_enter(PH_MACK, 8'h00);
                    end
                end
            end
            PH_MACK: begin
                if (t == 0) bus_scl = 1'b0;
                else if (t == 1) bus_sda = (bus_left <= 1);
                else if (t == 2) bus_scl = 1'b1;
                else bus_scl = 1'b0;
                if (t < 3) begin
                    bus_tick_n = t + 3'd1;
                end else begin
                    bus_left = bus_left - 5'd1;
                    if (bus_left == 0) bus_enter(PH_STOP, 8'h00);
                    else bus_enter(PH_RECV, 8'h00);
                end
            end
            PH_STOP: begin
                if (t == 0) bus_scl = 1'b0;
                else if (t == 1) bus_sda = 1'b0;
                else if (t == 2) bus_scl = 1'b1;
                else bus_sda = 1'b1;
                if (t < 3) begin
                    bus_tick_n = t + 3'd1;
                end else begin
                    bus_enter(PH_IDLE, 8'h00);
                    res.done_res = 1'b1;
                    res.status   = bus_abort;
                end
            end
            default: bus_enter(PH_IDLE, 8'h00);
        endcase
    endtask

    task automatic bus_step(input t_request rq, output t_result res);
        res = '0;
        case (t_op'(rq.op))
            OP_PUSH: begin
                if (bus_phase != PH_IDLE || bus_fill >= MAX_BYTES) begin
                    res.push_dropped = 1'b1;
                end else begin
                    bus_fifo[bus_fill[3:0]] = rq.data_byte;
                    bus_fill = bus_fill + 5'd1;
                end
            end
            OP_WRITE, OP_READ: begin
                if (bus_phase == PH_IDLE) begin
                    bus_rd    = (t_op'(rq.op) == OP_READ);
                    bus_reg   = rq.reg_addr;
                    bus_left  = (rq.length > MAX_BYTES) ? 5'(MAX_BYTES) : rq.length;
                    bus_idx   = '0;
                    bus_abort = ST_OK;
                    if (!bus_rd) bus_fill = '0;
                    bus_enter(PH_START1, 8'h00);
                end
            end
            default: begin
                if (bus_phase != PH_IDLE) bus_tick(rq.sda_in, res);
            end
        endcase
        res.scl_out  = bus_scl;
        res.sda_out  = bus_sda;
        res.busy_res = (bus_phase != PH_IDLE);
    endtask

    function automatic int draw_wait(t_pace mode);
        case (mode)
            PACE_FULL: return 0;
            PACE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
            default:   return $urandom_range(0, 16);
        endcase
    endfunction

    // driver: offers queued requests, holds them while stalled
    always @(posedge clk) begin
        t_result pred;
        if (!rst_n) begin
            in_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (in_valid && !in_stall) begin
                bus_step(in_req, pred);
                bus_drive_q.push_back(pred);
                accepted_n++;
                src_gap = draw_wait(src_mode);
            end
            if (in_valid && in_stall) begin
                // hold the stalled request
            end else if (src_gap > 0) begin
                in_valid <= 1'b0;
                src_gap--;
            end else if (request_q.size() > 0) begin
                in_req   <= request_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // one long hold so the output fills up and the input stalls
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && result_n >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: compares each result with the oldest prediction
    always @(posedge clk) begin
        t_result want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            sink_wait = 0;
        end else begin
            if (out_valid && !out_stall) begin
                result_n++;
                if (bus_drive_q.size() == 0) begin
                    mismatch_n++;
                    if (mismatch_n <= MAX_SHOWN)
                        $display("result %0d arrived with no request waiting for it", result_n);
                end else begin
                    want = bus_drive_q.pop_front();
                    if (out_res !== want) begin
                        mismatch_n++;
                        if (mismatch_n <= MAX_SHOWN)
                            $display({"result %0d (exp/got): scl %b/%b sda %b/%b busy %b/%b",
                                      " rvalid %b/%b rdata %h/%h rlast %b/%b done %b/%b",
                                      " status %0d/%0d dropped %b/%b"},
                                     result_n, want.scl_out, out_res.scl_out,
                                     want.sda_out, out_res.sda_out,
                                     want.busy_res, out_res.busy_res,
                                     want.read_valid, out_res.read_valid,
                                     want.read_data, out_res.read_data,
                                     want.read_last, out_res.read_last,
                                     want.done_res, out_res.done_res,
                                     want.status, out_res.status,
                                     want.push_dropped, out_res.push_dropped);
                    end
                end
                if (out_res.read_valid) bytes_read++;
                if (out_res.done_res) done_by_status[out_res.status]++;
                sink_wait = draw_wait(sink_mode);
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            out_stall <= (sink_wait > 0) || (hold_left > 0);
        end
    end

    function automatic t_request rand_req(t_op op);
        t_request r;
        r.op        = op;
        r.sda_in    = 1'($urandom_range(0, 1));
        r.reg_addr  = 8'($urandom);
        r.length    = 5'($urandom);
        r.data_byte = 8'($urandom);
        return r;
    endfunction

    task automatic add_req(t_request r);
        request_q.push_back(r);
        item_count++;
    endtask

    // tick outside a transfer, ignored by the block while idle
    task automatic add_idle(logic sdi);
        t_request r;
        r = rand_req(OP_TICK);
        r.sda_in = sdi;
        request_q.push_back(r);
    endtask

    task automatic push_byte(logic [7:0] b);
        t_request r;
        r = rand_req(OP_PUSH);
        r.data_byte = b;
        add_req(r);
    endtask

    task automatic tick(logic sdi);
        t_request r;
        // stray commands and pushes while busy
        if ($urandom_range(0, 99) < noise_pct) add_req(rand_req(t_op'($urandom_range(1, 3))));
        r = rand_req(OP_TICK);
        r.sda_in = sdi;
        add_req(r);
    endtask

    task automatic ticks_rand(int n);
        repeat (n) tick(1'($urandom_range(0, 1)));
    endtask

    task automatic start_seq(bit fail);
        int bad;
        logic want;
        bad = $urandom_range(1, 2);
        for (int t = 0; t < 5; t++) begin
            want = 1'($urandom_range(0, 1));
            if (t == 1) want = 1'b1;
            if (t == 2) want = 1'b0;
            if (fail && t == bad) begin
                tick(!want);
                return;
            end
            tick(want);
        end
    endtask

    task automatic ack_seq(logic nack);
        for (int t = 0; t < 7; t++) tick((t == 5) ? nack : 1'($urandom_range(0, 1)));
    endtask

    task automatic recv_byte();
        logic [7:0] b;
        b = 8'($urandom);
        for (int i = 7; i >= 0; i--) begin
            tick(1'($urandom_range(0, 1)));
            tick(b[i]);
        end
        ticks_rand(4);
    endtask

    // one well-formed transfer, optionally broken at one point
    task automatic transfer(t_op op, logic [7:0] reg_a, logic [4:0] len, t_fault flt);
        int nbytes;
        int nack_at;
        t_request r;
        nbytes  = (len > MAX_BYTES) ? MAX_BYTES : len;
        nack_at = (flt == FLT_DATA_NACK && nbytes > 0) ? $urandom_range(0, nbytes - 1) : -1;
        r = rand_req(op);
        r.reg_addr = reg_a;
        r.length   = len;
        add_req(r);
        start_seq(flt == FLT_START1);
        if (flt == FLT_START1) return;
        ticks_rand(24);
        ack_seq(flt == FLT_ADDR_NACK);
        if (flt == FLT_ADDR_NACK) begin
            ticks_rand(4);
            return;
        end
        ticks_rand(24);
        ack_seq(1'($urandom_range(0, 1)));
        if (op == OP_READ) begin
            start_seq(flt == FLT_START2);
            if (flt == FLT_START2) return;
            ticks_rand(24);
            ack_seq(1'($urandom_range(0, 1)));
            repeat (nbytes) recv_byte();
        end else begin
            for (int i = 0; i < nbytes; i++) begin
                ticks_rand(24);
                ack_seq(i == nack_at);
                if (i == nack_at) break;
            end
        end
        ticks_rand(4);
    endtask

    task automatic random_transfer();
        t_op op;
        logic [4:0] len;
        t_fault flt;
        int pick;
        if ($urandom_range(0, 1)) op = OP_WRITE;
        else op = OP_READ;
        len = 5'($urandom_range(0, 2));
        pick = $urandom_range(0, 19);
        if (pick < 14) flt = FLT_NONE;
        else flt = t_fault'((pick - 14) % 4 + 1);
        if (op == OP_WRITE) repeat ($urandom_range(0, 18)) push_byte(8'($urandom));
        repeat ($urandom_range(0, 2)) add_idle(1'($urandom_range(0, 1)));
        transfer(op, 8'($urandom), len, flt);
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (request_q.size() != 0 || in_valid || bus_drive_q.size() != 0);
    endtask

    // drain all results, then tick until the bus is back to idle
    task automatic settle();
        wait_drained();
        while (bus_phase != PH_IDLE) begin
            add_idle(1'b1);
            wait_drained();
        end
    endtask

    task automatic write_dev_addr(logic [6:0] a);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= a;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        bus_dev = a;
        @(negedge clk);
    endtask

    initial begin
        bus_reset();
        src_mode  = PACE_SOME;
        sink_mode = PACE_SOME;
        noise_pct = 4;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset address: buffer fill and overflow, a write, a failed start, an address nack
        add_idle(1'b0);
        add_idle(1'b1);
        push_byte(8'h00);
        push_byte(8'hFF);
        repeat (14) push_byte(8'($urandom));
        push_byte(8'hA5);
        transfer(OP_WRITE, 8'hFF, 5'd1, FLT_NONE);
        transfer(OP_WRITE, 8'h22, 5'd2, FLT_START1);
        transfer(OP_READ, 8'h44, 5'd31, FLT_ADDR_NACK);
        settle();

        // lowest address at full pace: a read and a write ended by a data nack
        write_dev_addr(7'h00);
        src_mode  = PACE_FULL;
        sink_mode = PACE_FULL;
        noise_pct = 2;
        transfer(OP_READ, 8'h5A, 5'd1, FLT_NONE);
        repeat (2) push_byte(8'($urandom));
        transfer(OP_WRITE, 8'h55, 5'd2, FLT_DATA_NACK);
        settle();

        // highest address, slow sender: repeated start that finds the bus busy
        write_dev_addr(7'h7F);
        src_mode  = PACE_HEAVY;
        sink_mode = PACE_SOME;
        noise_pct = 6;
        transfer(OP_READ, 8'h33, 5'd0, FLT_START2);
        settle();

        // random address, slow receiver
        write_dev_addr(7'($urandom));
        src_mode  = PACE_SOME;
        sink_mode = PACE_HEAVY;
        noise_pct = 6;
        random_transfer();
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d requests (%0d queued as transfer traffic), %0d results, %0d bytes read",
                 accepted_n, item_count, result_n, bytes_read);
        $display("endings: %0d ok, %0d bus busy, %0d addr nack, %0d data nack; %0d mismatches",
                 done_by_status[ST_OK], done_by_status[ST_BUS_BUSY],
                 done_by_status[ST_ADDR_NACK], done_by_status[ST_DATA_NACK], mismatch_n);
        if (mismatch_n == 0 && bus_drive_q.size() == 0) begin
            $display("tb_i2c_master_register_access passed");
        end else begin
            $display("tb_i2c_master_register_access failed");
        end
        $finish;
    end

    initial begin
        for (cycle_n = 0; cycle_n < CYCLE_LIMIT; cycle_n++) @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding", cycle_n, bus_drive_q.size());
        $display("tb_i2c_master_register_access failed");
        $finish;
    end

endmodule

/* i2c_master_register_access.f */
rtl/i2cmra_pkg.sv
rtl/i2c_master_register_access.sv
tb/sv/tb_i2c_master_register_access.sv
